>>> sv/dri_pkg.sv
// Shared types, widths and constants for the delta robot inverse kinematics pipeline.
`default_nettype none
package dri_pkg;

	localparam int ANGLE_FRACTION_BITS = 13;
	localparam int PRE_SHIFT = 5;

	localparam int COORD_W = 16;
	localparam int ANGLE_W = 16;
	localparam int CFG_W = 15;
	localparam int IDX_W = 3;

	localparam int EFG_W = 29;
	localparam int SQ_W = 2 * EFG_W;
	localparam int D_W = SQ_W + 1;
	localparam int RAD_W = 56;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = 32;
	localparam int N_W = 31;
	localparam int SHIFT_W = 5;
	localparam int NORM_BIT = 29;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

	typedef enum logic [IDX_W-1:0] {
		REG_UPPER_ARM = 3'd0,
		REG_LOWER_ARM = 3'd1,
		REG_OFFSET_A  = 3'd2,
		REG_OFFSET_B  = 3'd3,
		REG_OFFSET_C  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
		logic signed [COORD_W-1:0] target_z;
	} target_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_one;
		logic signed [ANGLE_W-1:0] angle_two;
		logic signed [ANGLE_W-1:0] angle_three;
		logic [2:0] unreachable_mask;
	} joint_t;

	typedef struct packed {
		logic [13:0] upper_arm_length;
		logic [14:0] lower_arm_length;
		logic signed [14:0] offset_a;
		logic signed [14:0] offset_b;
		logic signed [14:0] offset_c;
	} geom_t;

	// travels alongside the square root
	typedef struct packed {
		logic signed [EFG_W-1:0] f;
		logic signed [EFG_W:0] den;
		logic bad;
	} arm_side_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
		unique case (idx)
			5'd0: return 33'h03243F6A8;
			5'd1: return 33'h01DAC6705;
			5'd2: return 33'h00FADBAFC;
			5'd3: return 33'h007F56EA6;
			5'd4: return 33'h003FEAB76;
			5'd5: return 33'h001FFD55B;
			5'd6: return 33'h000FFFAAA;
			5'd7: return 33'h0007FFF55;
			5'd8: return 33'h0003FFFEA;
			5'd9: return 33'h0001FFFFD;
			5'd10: return 33'h0000FFFFF;
			5'd11: return 33'h00007FFFF;
			5'd12: return 33'h00003FFFF;
			5'd13: return 33'h00001FFFF;
			5'd14: return 33'h00000FFFF;
			5'd15: return 33'h000007FFF;
			5'd16: return 33'h000003FFF;
			5'd17: return 33'h000001FFF;
			5'd18: return 33'h000000FFF;
			5'd19: return 33'h0000007FF;
			5'd20: return 33'h0000003FF;
			5'd21: return 33'h0000001FF;
			5'd22: return 33'h0000000FF;
			5'd23: return 33'h00000007F;
			5'd24: return 33'h00000003F;
			5'd25: return 33'h00000001F;
			5'd26: return 33'h00000000F;
			5'd27: return 33'h000000008;
			5'd28: return 33'h000000004;
			5'd29: return 33'h000000002;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> sv/dri_front.sv
// Front end: forms the scaled E, F and G terms of all three arms in five stages.
`default_nettype none
module dri_front import dri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  target_t tgt,
	input  geom_t geom,
	output logic out_valid,
	output logic signed [EFG_W-1:0] e1,
	output logic signed [EFG_W-1:0] e2,
	output logic signed [EFG_W-1:0] e3,
	output logic signed [EFG_W-1:0] f,
	output logic signed [EFG_W-1:0] g1,
	output logic signed [EFG_W-1:0] g2,
	output logic signed [EFG_W-1:0] g3
);

	localparam int G_RAW_W = 35;
	localparam int IN_W = 36;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [15:0] x_s1, z_s1;
	logic signed [16:0] ya_s1, yc_s1, xpb_s1, xmb_s1;
	logic [13:0] lu_s1;
	logic [14:0] ll_s1;

	logic signed [31:0] sq_x_s2, sq_z_s2, lya_s2;
	logic signed [33:0] sq_ya_s2, sq_yc_s2, sq_xpb_s2, sq_xmb_s2;
	logic [27:0] sq_lu_s2;
	logic [29:0] sq_ll_s2;
	logic signed [30:0] zl_s2;
	logic signed [34:0] s3p_s2, s3m_s2;
	logic signed [16:0] yc_s2;
	logic [13:0] lu_s2;

	logic signed [G_RAW_W-1:0] common, g1_raw, g2_raw, g3_raw;
	logic signed [IN_W-1:0] in2, in3;

	logic signed [EFG_W-1:0] e1_s3, f_s3, g1_s3, g2_s3, g3_s3;
	logic signed [IN_W-1:0] in2_s3, in3_s3;
	logic [13:0] lu_s3;

	logic signed [EFG_W-1:0] e1_s4, f_s4, g1_s4, g2_s4, g3_s4;
	logic signed [50:0] p2_s4, p3_s4;

	logic signed [EFG_W-1:0] e1_s5, e2_s5, e3_s5, f_s5, g1_s5, g2_s5, g3_s5;

	always_comb begin
		common = G_RAW_W'(sq_z_s2) + G_RAW_W'($signed({1'b0, sq_lu_s2}))
			- G_RAW_W'($signed({1'b0, sq_ll_s2}));
		g1_raw = G_RAW_W'(sq_x_s2) + G_RAW_W'(sq_ya_s2) + common;
		g2_raw = G_RAW_W'(sq_xpb_s2) + G_RAW_W'(sq_yc_s2) + common;
		g3_raw = G_RAW_W'(sq_xmb_s2) + G_RAW_W'(sq_yc_s2) + common;
		in2 = -(IN_W'(s3p_s2) + (IN_W'(yc_s2) <<< 16));
		in3 = IN_W'(s3m_s2) - (IN_W'(yc_s2) <<< 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= tgt.target_x;
			z_s1 <= tgt.target_z;
			ya_s1 <= 17'(tgt.target_y) + 17'(geom.offset_a);
			yc_s1 <= 17'(tgt.target_y) + 17'(geom.offset_c);
			xpb_s1 <= 17'(tgt.target_x) + 17'(geom.offset_b);
			xmb_s1 <= 17'(tgt.target_x) - 17'(geom.offset_b);
			lu_s1 <= geom.upper_arm_length;
			ll_s1 <= geom.lower_arm_length;

			sq_x_s2 <= x_s1 * x_s1;
			sq_z_s2 <= z_s1 * z_s1;
			sq_ya_s2 <= ya_s1 * ya_s1;
			sq_yc_s2 <= yc_s1 * yc_s1;
			sq_xpb_s2 <= xpb_s1 * xpb_s1;
			sq_xmb_s2 <= xmb_s1 * xmb_s1;
			sq_lu_s2 <= lu_s1 * lu_s1;
			sq_ll_s2 <= ll_s1 * ll_s1;
			zl_s2 <= z_s1 * $signed({1'b0, lu_s1});
			lya_s2 <= $signed({1'b0, lu_s1}) * ya_s1;
			s3p_s2 <= SQRT3_Q16 * xpb_s1;
			s3m_s2 <= SQRT3_Q16 * xmb_s1;
			yc_s2 <= yc_s1;
			lu_s2 <= lu_s1;

			// 2*v >>> PRE_SHIFT equals v >>> (PRE_SHIFT-1)
			e1_s3 <= EFG_W'(lya_s2 >>> (PRE_SHIFT - 1));
			f_s3 <= EFG_W'(zl_s2 >>> (PRE_SHIFT - 1));
			g1_s3 <= EFG_W'(g1_raw >>> PRE_SHIFT);
			g2_s3 <= EFG_W'(g2_raw >>> PRE_SHIFT);
			g3_s3 <= EFG_W'(g3_raw >>> PRE_SHIFT);
			in2_s3 <= in2;
			in3_s3 <= in3;
			lu_s3 <= lu_s2;

			p2_s4 <= $signed({1'b0, lu_s3}) * in2_s3;
			p3_s4 <= $signed({1'b0, lu_s3}) * in3_s3;
			e1_s4 <= e1_s3;
			f_s4 <= f_s3;
			g1_s4 <= g1_s3;
			g2_s4 <= g2_s3;
			g3_s4 <= g3_s3;

			e1_s5 <= e1_s4;
			e2_s5 <= EFG_W'(p2_s4 >>> (16 + PRE_SHIFT));
			e3_s5 <= EFG_W'(p3_s4 >>> (16 + PRE_SHIFT));
			f_s5 <= f_s4;
			g1_s5 <= g1_s4;
			g2_s5 <= g2_s4;
			g3_s5 <= g3_s4;
		end
	end

	assign out_valid = valid_s5;
	assign e1 = e1_s5;
	assign e2 = e2_s5;
	assign e3 = e3_s5;
	assign f = f_s5;
	assign g1 = g1_s5;
	assign g2 = g2_s5;
	assign g3 = g3_s5;

endmodule
`default_nettype wire

>>> sv/dri_isqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
`default_nettype none
module dri_isqrt import dri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [RAD_W-1:0] rad,
	input  arm_side_t side,
	output logic out_valid,
	output logic [ROOT_W-1:0] root,
	output arm_side_t side_out
);

	logic valid_s [ROOT_W+1];
	logic [REM_W-1:0] rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [RAD_W-1:0] rad_s [ROOT_W+1];
	arm_side_t side_s [ROOT_W+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;
	assign side_s[0] = side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic take;

		always_comb begin
			rem_sh = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
			trial = REM_W'({root_s[k], 2'b01});
			take = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], take};
				rad_s[k+1] <= rad_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule
`default_nettype wire

>>> sv/dri_cordic.sv
// Pipelined CORDIC vectoring: arctangent of y/x in Q30 radians.
`default_nettype none
module dri_cordic import dri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [XY_W-1:0] x,
	input  logic signed [XY_W-1:0] y,
	input  logic bad,
	output logic out_valid,
	output logic signed [Z_W-1:0] z,
	output logic bad_out
);

	logic valid_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] z_s [CORDIC_STEPS+1];
	logic bad_s [CORDIC_STEPS+1];

	assign valid_s[0] = in_valid;
	assign x_s[0] = x;
	assign y_s[0] = y;
	assign z_s[0] = '0;
	assign bad_s[0] = bad;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic signed [XY_W-1:0] dx, dy;

		always_comb begin
			dx = x_s[i] >>> i;
			dy = y_s[i] >>> i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][XY_W-1]) begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - atan_q30(5'(i));
				end
				bad_s[i+1] <= bad_s[i];
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign z = z_s[CORDIC_STEPS];
	assign bad_out = bad_s[CORDIC_STEPS];

endmodule
`default_nettype wire

>>> sv/dri_arm.sv
// One arm: discriminant, square root, root choice, normalization, CORDIC and rounding.
`default_nettype none
module dri_arm import dri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [EFG_W-1:0] e,
	input  logic signed [EFG_W-1:0] f,
	input  logic signed [EFG_W-1:0] g,
	output logic out_valid,
	output logic signed [ANGLE_W-1:0] angle,
	output logic bad
);

	localparam int R_W = Z_W + 1;
	localparam logic signed [R_W-1:0] ROUND_ADD = R_W'(1) <<< (29 - ANGLE_FRACTION_BITS);
	localparam logic signed [XY_W-1:0] NORM_LIM = XY_W'(1) <<< NORM_BIT;

	function automatic logic [N_W-1:0] mag_n(input logic signed [N_W-1:0] v);
		return v[N_W-1] ? N_W'(-v) : N_W'(v);
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic signed [SQ_W-1:0] e_sq_s1, f_sq_s1, g_sq_s1;
	logic signed [EFG_W:0] den_s1;
	logic signed [EFG_W-1:0] f_s1;

	logic signed [D_W-1:0] disc;
	logic [RAD_W-1:0] rad_s2;
	arm_side_t side_s2;

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	arm_side_t sq_side;

	logic signed [N_W-1:0] np, nm, n_sel, n_fix, d_fix;
	logic signed [N_W-1:0] n_s3, d_s3;
	logic bad_s3;

	logic [N_W-1:0] m;
	logic [SHIFT_W-1:0] msb, k;
	logic signed [N_W-1:0] n_s4, d_s4;
	logic [SHIFT_W-1:0] k_s4;
	logic bad_s4;

	logic signed [XY_W-1:0] x_s5, y_s5;
	logic bad_s5;

	logic cd_valid, cd_bad;
	logic signed [Z_W-1:0] cd_z, z_clamp;
	logic signed [R_W-1:0] rnd;

	logic signed [ANGLE_W-1:0] angle_s6;
	logic bad_s6;

	always_comb begin
		disc = D_W'(e_sq_s1) + D_W'(f_sq_s1) - D_W'(g_sq_s1);
	end

	dri_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.rad      (rad_s2),
		.side     (side_s2),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	always_comb begin
		np = -N_W'(sq_side.f) + $signed({{(N_W-ROOT_W){1'b0}}, sq_root});
		nm = -N_W'(sq_side.f) - $signed({{(N_W-ROOT_W){1'b0}}, sq_root});
		n_sel = (mag_n(np) > mag_n(nm)) ? nm : np;
		if (sq_side.den[EFG_W]) begin
			n_fix = -n_sel;
			d_fix = -N_W'(sq_side.den);
		end else begin
			n_fix = n_sel;
			d_fix = N_W'(sq_side.den);
		end
	end

	always_comb begin
		m = mag_n(n_s3) | d_s3;
		msb = '0;
		for (int j = 0; j < N_W; j++) begin
			if (m[j]) begin
				msb = SHIFT_W'(j);
			end
		end
		k = (msb < SHIFT_W'(NORM_BIT)) ? SHIFT_W'(NORM_BIT) - msb : '0;
	end

	dri_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.x        (x_s5),
		.y        (y_s5),
		.bad      (bad_s5),
		.out_valid(cd_valid),
		.z        (cd_z),
		.bad_out  (cd_bad)
	);

	always_comb begin
		if (cd_z > HALF_PI_Q30) begin
			z_clamp = HALF_PI_Q30;
		end else if (cd_z < -HALF_PI_Q30) begin
			z_clamp = -HALF_PI_Q30;
		end else begin
			z_clamp = cd_z;
		end
		rnd = ((R_W'(z_clamp) <<< 1) + ROUND_ADD) >>> (30 - ANGLE_FRACTION_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= sq_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_sq_s1 <= e * e;
			f_sq_s1 <= f * f;
			g_sq_s1 <= g * g;
			den_s1 <= (EFG_W+1)'(g) - (EFG_W+1)'(e);
			f_s1 <= f;

			rad_s2 <= disc[RAD_W-1:0];
			side_s2.f <= f_s1;
			side_s2.den <= den_s1;
			side_s2.bad <= disc[D_W-1] || (den_s1 == '0);

			n_s3 <= n_fix;
			d_s3 <= d_fix;
			bad_s3 <= sq_side.bad;

			n_s4 <= n_s3;
			d_s4 <= d_s3;
			k_s4 <= k;
			bad_s4 <= bad_s3;

			x_s5 <= XY_W'(d_s4) <<< k_s4;
			y_s5 <= XY_W'(n_s4) <<< k_s4;
			bad_s5 <= bad_s4;

			angle_s6 <= cd_bad ? '0 : rnd[ANGLE_W-1:0];
			bad_s6 <= cd_bad;
		end
	end

	assign out_valid = valid_s6;
	assign angle = angle_s6;
	assign bad = bad_s6;

	a_norm_reached: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !bad_s5 |-> x_s5 >= NORM_LIM || y_s5 >= NORM_LIM || y_s5 <= -NORM_LIM)
		else $error("normalized vector below limit");

endmodule
`default_nettype wire

>>> sv/delta_robot_inverse_kinematics_top.sv
// Top level: geometry registers, front end, three arm lanes and the output register.
//
// Takes one target point per clock and returns the three joint angles through these stages:
// five front-end stages, two discriminant stages, a 28-stage square root, three stages
// of root choice and normalization, a 30-stage CORDIC, one rounding stage and the
// output register. Throughput is one transaction per cycle; a stalled output holds
// the whole pipeline. Geometry writes are taken at any time and should only be made
// while the pipeline is empty.
`default_nettype none
module delta_robot_inverse_kinematics_top import dri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic target_valid,
	output logic target_stall,
	input  target_t target,
	output logic joint_valid,
	input  logic joint_stall,
	output joint_t joint
);

	geom_t geom_q;
	logic en;

	logic fe_valid;
	logic signed [EFG_W-1:0] e1, e2, e3, f, g1, g2, g3;

	logic [2:0] arm_valid, arm_bad;
	logic signed [ANGLE_W-1:0] ang1, ang2, ang3;

	logic out_valid_q;
	joint_t joint_q;

	assign en = !out_valid_q || !joint_stall;
	assign target_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.upper_arm_length <= 14'd3200;
			geom_q.lower_arm_length <= 15'd6400;
			geom_q.offset_a <= 15'sd800;
			geom_q.offset_b <= 15'sd693;
			geom_q.offset_c <= 15'sd400;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_UPPER_ARM: geom_q.upper_arm_length <= cfg_data[13:0];
				REG_LOWER_ARM: geom_q.lower_arm_length <= cfg_data;
				REG_OFFSET_A: geom_q.offset_a <= cfg_data;
				REG_OFFSET_B: geom_q.offset_b <= cfg_data;
				REG_OFFSET_C: geom_q.offset_c <= cfg_data;
				default: ;
			endcase
		end
	end

	dri_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (target_valid),
		.tgt      (target),
		.geom     (geom_q),
		.out_valid(fe_valid),
		.e1       (e1),
		.e2       (e2),
		.e3       (e3),
		.f        (f),
		.g1       (g1),
		.g2       (g2),
		.g3       (g3)
	);

	dri_arm u_arm_one (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fe_valid),
		.e(e1), .f(f), .g(g1),
		.out_valid(arm_valid[0]), .angle(ang1), .bad(arm_bad[0])
	);

	dri_arm u_arm_two (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fe_valid),
		.e(e2), .f(f), .g(g2),
		.out_valid(arm_valid[1]), .angle(ang2), .bad(arm_bad[1])
	);

	dri_arm u_arm_three (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fe_valid),
		.e(e3), .f(f), .g(g3),
		.out_valid(arm_valid[2]), .angle(ang3), .bad(arm_bad[2])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= &arm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			joint_q.angle_one <= ang1;
			joint_q.angle_two <= ang2;
			joint_q.angle_three <= ang3;
			joint_q.unreachable_mask <= arm_bad;
		end
	end

	assign joint_valid = out_valid_q;
	assign joint = joint_q;

	a_unreachable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid |->
			(!joint.unreachable_mask[0] || joint.angle_one == '0) &&
			(!joint.unreachable_mask[1] || joint.angle_two == '0) &&
			(!joint.unreachable_mask[2] || joint.angle_three == '0))
		else $error("unreachable arm with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid && !joint.unreachable_mask[0] |->
			joint.angle_one <= 16'sd25736 && joint.angle_one >= -16'sd25736)
		else $error("angle outside half-pi clamp");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		target_stall |-> joint_valid && joint_stall)
		else $error("input stalled without a held transaction");

endmodule
`default_nettype wire
